### hdl/tlbff_pkg.sv
// ----------------------------------------------------------------------------
// tlbff_pkg
// Shared constants and control types for the FIFO-fill TLB.
// ----------------------------------------------------------------------------
package tlbff_pkg;

  localparam int TLB_ENTRIES = 8;
  localparam int PAGE_BYTES  = 1024;   // power of two
  localparam int ADDR_BITS   = 32;

  localparam int OFS_BITS  = $clog2(PAGE_BYTES);
  localparam int PAGE_BITS = ADDR_BITS - OFS_BITS;
  localparam int IDX_BITS  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int STAMP_BITS = 32;
  localparam int FIELD_BITS = 32;
  localparam int SLOT_BITS  = 3;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_FILL   = 1'b1;

  typedef struct packed {
    logic load;
    logic search;
    logic scan_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic req_fill;
    logic free_any;
    logic scan_last;
  } dp_status_t;

endpackage

### hdl/tlbff_ctrl.sv
// ----------------------------------------------------------------------------
// tlbff_ctrl
// Sequencer: accept, parallel search, oldest-entry scan, result hand-off.
// ----------------------------------------------------------------------------
module tlbff_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tlbff_pkg::ctrl_cmd_t  cmd,
  input  tlbff_pkg::dp_status_t status
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next    = state;
    cmd.load      = 1'b0;
    cmd.search    = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.out_load  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (!status.req_fill || status.free_any || tlbff_pkg::TLB_ENTRIES == 1) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_to_search: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_SEARCH)
    else $error("accepted item did not start a search");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_valid && !out_ready |=> state == S_DONE)
    else $error("result dropped while output stalled");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  a_scan_only_fill: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> status.req_fill)
    else $error("oldest scan on a lookup");

endmodule

### hdl/tlbff_dpath.sv
// ----------------------------------------------------------------------------
// tlbff_dpath
// Entry store, tag compare, free and oldest search, result register.
// ----------------------------------------------------------------------------
module tlbff_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  tlbff_pkg::ctrl_cmd_t                cmd,
  output tlbff_pkg::dp_status_t               status,
  input  logic                                in_cmd,
  input  logic [tlbff_pkg::FIELD_BITS-1:0]    in_virt,
  input  logic [tlbff_pkg::FIELD_BITS-1:0]    in_phys,
  input  logic [tlbff_pkg::STAMP_BITS-1:0]    in_stamp,
  output logic                                hit,
  output logic [tlbff_pkg::FIELD_BITS-1:0]    result_addr,
  output logic [tlbff_pkg::SLOT_BITS-1:0]     slot
);

  localparam int N  = tlbff_pkg::TLB_ENTRIES;
  localparam int AB = tlbff_pkg::ADDR_BITS;
  localparam int OB = tlbff_pkg::OFS_BITS;
  localparam int PB = tlbff_pkg::PAGE_BITS;
  localparam int IB = tlbff_pkg::IDX_BITS;
  localparam int SB = tlbff_pkg::STAMP_BITS;

  logic          req_cmd;
  logic [AB-1:0] req_va;
  logic [AB-1:0] req_pa;
  logic [SB-1:0] req_stamp;

  logic [N-1:0]  entry_valid;
  logic [PB-1:0] entry_page    [N];
  logic [PB-1:0] entry_frame   [N];
  logic [SB-1:0] entry_created [N];

  logic [PB-1:0] va_page;
  logic [PB-1:0] pa_page;
  logic [OB-1:0] va_ofs;

  logic          match_any;
  logic [IB-1:0] match_idx;
  logic          free_any;
  logic [IB-1:0] free_idx;

  logic          hit_r;
  logic [IB-1:0] sel_idx;
  logic [IB-1:0] scan_idx;
  logic [SB-1:0] best;

  assign va_page = req_va[AB-1:OB];
  assign va_ofs  = req_va[OB-1:0];
  assign pa_page = req_pa[AB-1:OB];

  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    free_any  = 1'b0;
    free_idx  = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (entry_valid[i] && entry_page[i] == va_page) begin
        match_any = 1'b1;
        match_idx = IB'(i);
      end
      if (!entry_valid[i]) begin
        free_any = 1'b1;
        free_idx = IB'(i);
      end
    end
  end

  assign status.req_fill  = (req_cmd == tlbff_pkg::CMD_FILL);
  assign status.free_any  = free_any;
  assign status.scan_last = (scan_idx == IB'(N - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd   <= in_cmd;
      req_va    <= AB'(in_virt);
      req_pa    <= AB'(in_phys);
      req_stamp <= in_stamp;
    end
    if (cmd.search) begin
      best     <= entry_created[0];
      scan_idx <= IB'(1);
      if (req_cmd == tlbff_pkg::CMD_LOOKUP) begin
        hit_r   <= match_any;
        sel_idx <= match_any ? match_idx : '0;
      end else begin
        hit_r   <= 1'b0;
        sel_idx <= free_any ? free_idx : '0;
      end
    end
    if (cmd.scan_step) begin
      if (entry_created[scan_idx] < best) begin
        best    <= entry_created[scan_idx];
        sel_idx <= scan_idx;
      end
      scan_idx <= scan_idx + IB'(1);
    end
    if (cmd.out_load) begin
      hit         <= hit_r;
      slot        <= tlbff_pkg::SLOT_BITS'(sel_idx);
      result_addr <= hit_r ? tlbff_pkg::FIELD_BITS'({entry_frame[sel_idx], va_ofs}) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load && req_cmd == tlbff_pkg::CMD_FILL) begin
      entry_page[sel_idx]    <= va_page;
      entry_frame[sel_idx]   <= pa_page;
      entry_created[sel_idx] <= req_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.out_load && req_cmd == tlbff_pkg::CMD_FILL) begin
      entry_valid[sel_idx] <= 1'b1;
    end
  end

endmodule

### hdl/tlb_lookup_fifo_fill.sv
// ----------------------------------------------------------------------------
// tlb_lookup_fifo_fill
// Fully associative TLB, lookup and fill, first-free then oldest-created
// replacement.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   cmd, virt_addr, phys_addr, stamp
//   out      out_valid / out_ready hit, result_addr, slot
//
// Lookups and fills into a free entry go through accept, parallel compare
// and result load; a fill into a full TLB adds the one-entry-per-cycle
// oldest-date scan. One item is in work at a time; a new one is taken
// while the result waits. Reset clears all valid bits; an output stall
// holds the item in its final state.
// ----------------------------------------------------------------------------
module tlb_lookup_fifo_fill (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] virt_addr,
  input  logic [31:0] phys_addr,
  input  logic [31:0] stamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [31:0] result_addr,
  output logic [2:0]  slot
);

  tlbff_pkg::ctrl_cmd_t  ctl;
  tlbff_pkg::dp_status_t sts;

  tlbff_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (ctl),
    .status    (sts)
  );

  tlbff_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (ctl),
    .status      (sts),
    .in_cmd      (cmd),
    .in_virt     (virt_addr),
    .in_phys     (phys_addr),
    .in_stamp    (stamp),
    .hit         (hit),
    .result_addr (result_addr),
    .slot        (slot)
  );

endmodule
